@@ design/packed_pattern_decoder_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the packed pattern decoder
// Immediate-implication and next-cycle forms on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef PACKED_PATTERN_DECODER_TOP_ASSERT_SVH
`define PACKED_PATTERN_DECODER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define PPD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PPD_ASSERT_NOW(lbl, ante, cons, msg)
`define PPD_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ design/ppd_pkg.sv @@
// ----------------------------------------------------------------------------
// ppd_pkg
// Types, constants and decode helpers of the packed pattern decoder.
// ----------------------------------------------------------------------------
package ppd_pkg;

  localparam int CHANNELS_DEF = 64;
  localparam int MAX_ROWS_DEF = 256;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_ZXX   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_ROWS = 2'd1;

  localparam logic [8:0] PATTERN_ROWS_RST = 9'd64;

  localparam logic [7:0] ZXX_EFFECT = 8'd26;

  localparam logic [7:0] NOTE_BYTE_OFF = 8'd255;
  localparam logic [7:0] NOTE_BYTE_CUT = 8'd254;
  localparam logic [7:0] NOTE_BYTE_MAX = 8'd119;
  localparam logic [6:0] KEY_OFF_CODE  = 7'd120;
  localparam logic [6:0] KEY_CUT_CODE  = 7'd121;
  localparam logic [6:0] KEY_FADE_CODE = 7'd122;

  // volume byte ranges
  localparam logic [7:0] VOL_SET_MAX   = 8'd64;
  localparam logic [7:0] VOL_FX_BASE   = 8'd65;
  localparam logic [7:0] VOL_FX_MAX    = 8'd124;
  localparam logic [7:0] VOL_PAN_BASE  = 8'd128;
  localparam logic [7:0] VOL_PAN_MAX   = 8'd192;
  localparam logic [7:0] VOL_PT_BASE   = 8'd193;
  localparam logic [7:0] VOL_PT_MAX    = 8'd212;

  // volume kinds, stored as kind + 1 (0 means no volume)
  localparam logic [3:0] VK_NONE   = 4'd0;
  localparam logic [3:0] VK_VOLUME = 4'd1;
  localparam logic [3:0] VK_PAN    = 4'd2;
  localparam logic [3:0] VK_FX     = 4'd3;
  localparam logic [3:0] VK_PT     = 4'd9;

  typedef enum logic [2:0] {
    PH_CHAN,
    PH_MASK,
    PH_NOTE,
    PH_INST,
    PH_VOL,
    PH_EFF,
    PH_PARAM
  } phase_e;

  // one channel's remembered cell
  typedef struct packed {
    logic [6:0] note;       // 0 none, else note code + 1
    logic [7:0] instrument;
    logic [3:0] volk;       // 0 none, else volume kind + 1
    logic [6:0] volp;
    logic [7:0] effect;
    logic [7:0] param;
  } entry_t;

  typedef struct packed {
    entry_t ent;
    logic   dropped;
  } pend_t;

  typedef struct packed {
    logic       kind;
    logic       last_row;
    logic [7:0] row;
    logic [5:0] channel;
    logic [3:0] present;
    logic [6:0] note_code;
    logic [7:0] instrument;
    logic [3:0] vol_kind;
    logic [6:0] vol_param;
    logic [7:0] effect;
    logic [7:0] param;
    logic       zxx_dropped;
  } result_t;

  typedef struct packed {
    logic [3:0] kind;
    logic [6:0] parm;
  } vol_t;

  function automatic logic [6:0] decode_note_byte(logic [7:0] b);
    logic [6:0] code;
    if (b == NOTE_BYTE_OFF) begin
      code = KEY_OFF_CODE;
    end else if (b == NOTE_BYTE_CUT) begin
      code = KEY_CUT_CODE;
    end else if (b > NOTE_BYTE_MAX) begin
      code = KEY_FADE_CODE;
    end else begin
      code = b[6:0];
    end
    return code;
  endfunction

  // quotient by ten through thresholds, the values stay below 60
  function automatic vol_t vol_decode(logic [7:0] v);
    logic [7:0] d;
    logic [2:0] q;
    vol_t       r;
    r = '0;
    d = '0;
    q = '0;
    if (v <= VOL_SET_MAX) begin
      r.kind = VK_VOLUME;
      r.parm = v[6:0];
    end else if (v <= VOL_FX_MAX) begin
      d = v - VOL_FX_BASE;
      q = 3'(d >= 8'd10) + 3'(d >= 8'd20) + 3'(d >= 8'd30)
        + 3'(d >= 8'd40) + 3'(d >= 8'd50);
      r.kind = VK_FX + 4'(q);
      r.parm = 7'(d - 8'(q) * 8'd10);
    end else if (v >= VOL_PAN_BASE && v <= VOL_PAN_MAX) begin
      r.kind = VK_PAN;
      r.parm = 7'(v - VOL_PAN_BASE);
    end else if (v >= VOL_PT_BASE && v <= VOL_PT_MAX) begin
      d = v - VOL_PT_BASE;
      q = 3'(d >= 8'd10);
      r.kind = VK_PT + 4'(q);
      r.parm = 7'(d - 8'(q) * 8'd10);
    end
    return r;
  endfunction

endpackage

@@ design/ppd_if.sv @@
// ----------------------------------------------------------------------------
// ppd_if
// Valid/ready channels of the packed pattern decoder: stream bytes in,
// decoded cells out, configuration writes in.
// ----------------------------------------------------------------------------
interface ppd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

interface ppd_cell_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic       last_row;
  logic [7:0] row;
  logic [5:0] channel;
  logic [3:0] present;
  logic [6:0] note_code;
  logic [7:0] instrument;
  logic [3:0] vol_kind;
  logic [6:0] vol_param;
  logic [7:0] effect;
  logic [7:0] param;
  logic       zxx_dropped;

  modport source (output valid, output kind, output last_row, output row,
                  output channel, output present, output note_code,
                  output instrument, output vol_kind, output vol_param,
                  output effect, output param, output zxx_dropped, input ready);
  modport sink   (input valid, input kind, input last_row, input row,
                  input channel, input present, input note_code,
                  input instrument, input vol_kind, input vol_param,
                  input effect, input param, input zxx_dropped, output ready);
endinterface

interface ppd_cfg_if;
  import ppd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/packed_pattern_decoder_top.sv @@
// ----------------------------------------------------------------------------
// packed_pattern_decoder_top
// Decodes a packed tracker pattern stream into cells and row-end marks,
// keeping each channel's last mask and last cell in two RAMs.
// ----------------------------------------------------------------------------
//  port     dir  request                       note
//  stream_i in   one packed pattern byte       valid/ready
//  cell_o   out  one decoded cell or row end   valid/ready, registered
//  cfg_i    in   register write (index, data)  always ready
//
// One byte a cycle sustained. A byte is decoded the cycle after it is taken,
// once the RAM read issued on acceptance returns; its result sits in the
// output register once decode fires. Same-entry write/read overlap is
// forwarded. Reset and the final row end clear the per-entry valid bits at
// once, so no clearing pass. A stalled output holds the decode stage; input
// stalls only when both the decode stage and the output register are full.
// ----------------------------------------------------------------------------
`include "packed_pattern_decoder_top_assert.svh"

module packed_pattern_decoder_top #(
  parameter int CHANNELS = ppd_pkg::CHANNELS_DEF,
  parameter int MAX_ROWS = ppd_pkg::MAX_ROWS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ppd_byte_if.sink   stream_i,
  ppd_cell_if.source cell_o,
  ppd_cfg_if.sink    cfg_i
);

  import ppd_pkg::*;

  localparam int IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RowW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int EntW = $bits(entry_t);

  typedef logic [IdxW-1:0] mod_tab_t [64];

  function automatic mod_tab_t build_mod_tab();
    mod_tab_t tab;
    for (int i = 0; i < 64; i++) begin
      tab[i] = IdxW'(i % CHANNELS);
    end
    return tab;
  endfunction

  // channel number to RAM entry
  localparam mod_tab_t ModTab = build_mod_tab();

  // configuration
  logic       ignore_zxx_q;
  logic [8:0] pattern_rows_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ignore_zxx_q   <= 1'b0;
      pattern_rows_q <= PATTERN_ROWS_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_IGNORE_ZXX:   ignore_zxx_q   <= cfg_i.data[0];
        REG_PATTERN_ROWS: pattern_rows_q <= cfg_i.data[8:0];
        default: ;
      endcase
    end
  end

  // decode stage
  logic       s1_vld_q;
  logic [7:0] s1_byte_q;
  logic       s1_fire;
  logic       in_acc;
  logic       out_vld_q;
  result_t    res_q;

  assign s1_fire         = s1_vld_q && (!out_vld_q || cell_o.ready);
  assign stream_i.ready  = !s1_vld_q || s1_fire;
  assign in_acc          = stream_i.valid && stream_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_acc) begin
      s1_vld_q <= 1'b1;
    end else if (s1_fire) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= stream_i.stream_byte;
    end
  end

  // RAMs and valid bits
  logic [IdxW-1:0]     raddr;
  logic [IdxW-1:0]     waddr;
  logic                we_m;
  logic                we_c;
  logic [7:0]          m_wdata;
  entry_t              c_wdata;
  logic [7:0]          m_rdata;
  logic [EntW-1:0]     c_rdata;
  logic [CHANNELS-1:0] mask_vld_q;
  logic [CHANNELS-1:0] cell_vld_q;
  logic                clr_now;

  assign raddr = ModTab[stream_i.stream_byte[5:0] - 6'd1];

  ppd_ram #(.Width(8), .Depth(CHANNELS)) u_mask_ram (
    .clk_i   (clk_i),
    .we_i    (we_m),
    .waddr_i (waddr),
    .wdata_i (m_wdata),
    .re_i    (in_acc),
    .raddr_i (raddr),
    .rdata_o (m_rdata)
  );

  ppd_ram #(.Width(EntW), .Depth(CHANNELS)) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (we_c),
    .waddr_i (waddr),
    .wdata_i (c_wdata),
    .re_i    (in_acc),
    .raddr_i (raddr),
    .rdata_o (c_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_vld_q <= '0;
      cell_vld_q <= '0;
    end else if (clr_now) begin
      mask_vld_q <= '0;
      cell_vld_q <= '0;
    end else begin
      if (we_m) mask_vld_q[waddr] <= 1'b1;
      if (we_c) cell_vld_q[waddr] <= 1'b1;
    end
  end

  // read-side snapshot of writes and clears landing in the read cycle
  logic       m_vld_q, m_fwd_q, c_vld_q, c_fwd_q, clr_q;
  logic [7:0] m_fwd_data_q;
  entry_t     c_fwd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
      m_fwd_q <= 1'b0;
      c_vld_q <= 1'b0;
      c_fwd_q <= 1'b0;
      clr_q   <= 1'b0;
    end else if (in_acc) begin
      m_vld_q <= mask_vld_q[raddr];
      m_fwd_q <= we_m && (waddr == raddr);
      c_vld_q <= cell_vld_q[raddr];
      c_fwd_q <= we_c && (waddr == raddr);
      clr_q   <= clr_now;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      m_fwd_data_q <= m_wdata;
      c_fwd_data_q <= c_wdata;
    end
  end

  logic [7:0] rd_mask;
  entry_t     rd_ent;

  always_comb begin
    if (clr_q) begin
      rd_mask = '0;
      rd_ent  = '0;
    end else begin
      rd_mask = m_fwd_q ? m_fwd_data_q : (m_vld_q ? m_rdata : 8'd0);
      rd_ent  = c_fwd_q ? c_fwd_data_q : (c_vld_q ? entry_t'(c_rdata) : entry_t'('0));
    end
  end

  // decode state
  phase_e          phase_q, phase_d;
  logic [5:0]      chan_q, chan_d;
  logic [7:0]      mask_q, mask_d;
  logic [RowW-1:0] row_q, row_d;
  pend_t           pend_q, pend_d;
  entry_t          ent_q, ent_d;

  logic       res_vld;
  result_t    res;
  logic       row_end;
  logic       last;
  logic       clr;
  logic       adv_en;
  phase_e     adv_from;
  logic       fin;
  logic [8:0] rows_eff;
  vol_t       vd;
  logic [7:0] m;

  assign rows_eff = (pattern_rows_q > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : pattern_rows_q;
  assign last     = (10'(row_q) + 10'd1) >= {1'b0, rows_eff};
  assign waddr    = ModTab[chan_q];
  assign vd       = vol_decode(s1_byte_q);

  always_comb begin
    phase_d  = phase_q;
    chan_d   = chan_q;
    mask_d   = mask_q;
    row_d    = row_q;
    pend_d   = pend_q;
    ent_d    = ent_q;
    res      = '0;
    res_vld  = 1'b0;
    row_end  = 1'b0;
    clr      = 1'b0;
    adv_en   = 1'b0;
    adv_from = PH_NOTE;
    fin      = 1'b0;
    m_wdata  = s1_byte_q;
    we_m     = 1'b0;
    we_c     = 1'b0;

    case (phase_q)
      PH_CHAN: begin
        if (s1_byte_q == 8'd0) begin
          row_end      = 1'b1;
          res_vld      = 1'b1;
          res.kind     = 1'b1;
          res.last_row = last;
          res.row      = 8'(row_q);
          if (last) begin
            row_d = '0;
            clr   = 1'b1;
          end else begin
            row_d = row_q + RowW'(1);
          end
        end else begin
          chan_d = s1_byte_q[5:0] - 6'd1;
          pend_d = '0;
          ent_d  = rd_ent;
          if (s1_byte_q[7]) begin
            phase_d = PH_MASK;
          end else begin
            mask_d   = rd_mask;
            adv_en   = 1'b1;
            adv_from = PH_NOTE;
          end
        end
      end
      PH_MASK: begin
        mask_d   = s1_byte_q;
        we_m     = 1'b1;
        adv_en   = 1'b1;
        adv_from = PH_NOTE;
      end
      PH_NOTE: begin
        pend_d.ent.note = decode_note_byte(s1_byte_q) + 7'd1;
        ent_d.note      = pend_d.ent.note;
        we_c            = 1'b1;
        adv_en          = 1'b1;
        adv_from        = PH_INST;
      end
      PH_INST: begin
        pend_d.ent.instrument = s1_byte_q;
        ent_d.instrument      = s1_byte_q;
        we_c                  = 1'b1;
        adv_en                = 1'b1;
        adv_from              = PH_VOL;
      end
      PH_VOL: begin
        pend_d.ent.volk = vd.kind;
        pend_d.ent.volp = vd.parm;
        ent_d.volk      = vd.kind;
        ent_d.volp      = vd.parm;
        we_c            = 1'b1;
        adv_en          = 1'b1;
        adv_from        = PH_EFF;
      end
      PH_EFF: begin
        pend_d.ent.effect = s1_byte_q;
        phase_d           = PH_PARAM;
      end
      PH_PARAM: begin
        pend_d.ent.param = s1_byte_q;
        if (ignore_zxx_q && pend_q.ent.effect == ZXX_EFFECT) begin
          pend_d.ent.effect = '0;
          pend_d.dropped    = 1'b1;
        end
        ent_d.effect = pend_d.ent.effect;
        ent_d.param  = pend_d.ent.param;
        we_c         = 1'b1;
        fin          = 1'b1;
      end
      default: begin
        phase_d = PH_CHAN;
      end
    endcase

    m = mask_d;

    // next byte the mask asks for, else the cell is complete
    if (adv_en) begin
      if (adv_from <= PH_NOTE && m[0]) begin
        phase_d = PH_NOTE;
      end else if (adv_from <= PH_INST && m[1]) begin
        phase_d = PH_INST;
      end else if (adv_from <= PH_VOL && m[2]) begin
        phase_d = PH_VOL;
      end else if (adv_from <= PH_EFF && m[3]) begin
        phase_d = PH_EFF;
      end else begin
        fin = 1'b1;
      end
    end

    if (fin) begin
      // copied fields are untouched in this cell, so the entry still holds them
      if (!m[0] && m[4]) pend_d.ent.note = ent_d.note;
      if (!m[1] && m[5]) pend_d.ent.instrument = ent_d.instrument;
      if (!m[2] && m[6]) begin
        pend_d.ent.volk = ent_d.volk;
        pend_d.ent.volp = ent_d.volp;
      end
      if (!m[3] && m[7]) begin
        pend_d.ent.effect = ent_d.effect;
        pend_d.ent.param  = ent_d.param;
      end
      res_vld         = 1'b1;
      res.row         = 8'(row_q);
      res.channel     = chan_d;
      res.present     = {(m & 8'h88) != 8'd0, pend_d.ent.volk != VK_NONE,
                         (m & 8'h22) != 8'd0, pend_d.ent.note != 7'd0};
      res.note_code   = (pend_d.ent.note != 7'd0) ? pend_d.ent.note - 7'd1 : 7'd0;
      res.instrument  = pend_d.ent.instrument;
      res.vol_kind    = (pend_d.ent.volk != VK_NONE) ? pend_d.ent.volk - 4'd1 : 4'd0;
      res.vol_param   = (pend_d.ent.volk != VK_NONE) ? pend_d.ent.volp : 7'd0;
      res.effect      = pend_d.ent.effect;
      res.param       = pend_d.ent.param;
      res.zxx_dropped = pend_d.dropped;
      phase_d         = PH_CHAN;
    end

    c_wdata = ent_d;
    we_m    = we_m && s1_fire;
    we_c    = we_c && s1_fire;
  end

  assign clr_now = s1_fire && clr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CHAN;
      chan_q  <= '0;
      mask_q  <= '0;
      row_q   <= '0;
      pend_q  <= '0;
      ent_q   <= '0;
    end else if (s1_fire) begin
      phase_q <= phase_d;
      chan_q  <= chan_d;
      mask_q  <= mask_d;
      row_q   <= row_d;
      pend_q  <= pend_d;
      ent_q   <= ent_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_fire && res_vld) begin
      out_vld_q <= 1'b1;
    end else if (cell_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && res_vld) begin
      res_q <= res;
    end
  end

  assign cell_o.valid       = out_vld_q;
  assign cell_o.kind        = res_q.kind;
  assign cell_o.last_row    = res_q.last_row;
  assign cell_o.row         = res_q.row;
  assign cell_o.channel     = res_q.channel;
  assign cell_o.present     = res_q.present;
  assign cell_o.note_code   = res_q.note_code;
  assign cell_o.instrument  = res_q.instrument;
  assign cell_o.vol_kind    = res_q.vol_kind;
  assign cell_o.vol_param   = res_q.vol_param;
  assign cell_o.effect      = res_q.effect;
  assign cell_o.param       = res_q.param;
  assign cell_o.zxx_dropped = res_q.zxx_dropped;

  // checks
  `PPD_ASSERT_NXT(a_final_row_clears, clr_now, (mask_vld_q == '0) && (cell_vld_q == '0), "valid bits survived the final row end")
  `PPD_ASSERT_NOW(a_no_write_on_row_end, we_m || we_c, !row_end, "RAM write during a row end")
  `PPD_ASSERT_NOW(a_stall_blocks_input, s1_vld_q && out_vld_q && !cell_o.ready, !stream_i.ready, "byte taken while decode stage is blocked")
  `PPD_ASSERT_NXT(a_result_loaded, s1_fire && res_vld, out_vld_q, "decoded result not presented")

endmodule

@@ design/ppd_ram.sv @@
// ----------------------------------------------------------------------------
// ppd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ppd_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
